FILE: design/slm_pkg.sv
// shared constants and types for the sorted list merge block
package slm_pkg;

  // default list capacity
  localparam int LIST_DEPTH = 32;

  // width of one stored word
  localparam int VALUE_W = 32;

  // command codes
  typedef enum logic [1:0] {
    CMD_APPEND_A = 2'd0,
    CMD_APPEND_B = 2'd1,
    CMD_MERGE    = 2'd2,
    CMD_NONE     = 2'd3
  } cmd_t;

  // sequencer states, one-hot
  typedef enum logic [1:0] {
    ST_IDLE  = 2'b01,
    ST_MERGE = 2'b10
  } state_t;

endpackage

FILE: design/sorted_list_merge.sv
// top level: two sorted lists loaded word by word, merged on command
// an append gives no result and leaves the block ready
// merge: first result via merge state, ram read and result register, then one word per cycle
// an empty merge gives its single result in the cycle after the command and stays ready
// the pace is set by one head compare per cycle and the registered read of each list ram
// synchronous active-high reset clears counts, flag and sequencer; list contents are kept
module sorted_list_merge #(
  parameter int LIST_DEPTH = slm_pkg::LIST_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  output logic                       busy,
  input  logic [1:0]                 command,
  input  logic signed [slm_pkg::VALUE_W-1:0] value,
  output logic                       strobe,
  output logic signed [slm_pkg::VALUE_W-1:0] value_res,
  output logic                       last,
  output logic                       empty_res,
  output logic                       dropped
);

  localparam int AW = (LIST_DEPTH > 1) ? $clog2(LIST_DEPTH) : 1;
  localparam int CW = $clog2(LIST_DEPTH + 1);

  slm_pkg::state_t state;
  logic [CW-1:0]   cnt_a, cnt_b, ia, ib, ia_next, ib_next;
  logic            flag, drop_hold;
  logic            accept, take_b, final_word;
  logic            we_a, we_b;
  logic [CW:0]     total, emitted;
  logic [slm_pkg::VALUE_W-1:0] rd_a, rd_b;

  assign busy   = (state != slm_pkg::ST_IDLE);
  assign accept = start && !busy;

  // append writes, dropped when the list is full
  assign we_a = accept && (command == slm_pkg::CMD_APPEND_A) && (cnt_a < CW'(LIST_DEPTH));
  assign we_b = accept && (command == slm_pkg::CMD_APPEND_B) && (cnt_b < CW'(LIST_DEPTH));

  assign total      = {1'b0, cnt_a} + {1'b0, cnt_b};
  assign emitted    = {1'b0, ia} + {1'b0, ib} + (CW+1)'(1);
  assign final_word = (emitted == total);

  // head select, tie goes to list b
  always_comb begin
    priority if (ia >= cnt_a) begin
      take_b = 1'b1;
    end else if (ib >= cnt_b) begin
      take_b = 1'b0;
    end else begin
      take_b = ($signed(rd_b) <= $signed(rd_a));
    end
  end

  // next read indices, the rams read one ahead
  always_comb begin
    ia_next = ia;
    ib_next = ib;
    unique case (state)
      slm_pkg::ST_IDLE: begin
        ia_next = '0;
        ib_next = '0;
      end
      slm_pkg::ST_MERGE: begin
        if (final_word) begin
          ia_next = '0;
          ib_next = '0;
        end else if (take_b) begin
          ib_next = ib + CW'(1);
        end else begin
          ia_next = ia + CW'(1);
        end
      end
      default: begin
        ia_next = '0;
        ib_next = '0;
      end
    endcase
  end

  slm_ram #(.WIDTH(slm_pkg::VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_a (
    .clk   (clk),
    .we    (we_a),
    .waddr (cnt_a[AW-1:0]),
    .wdata (value),
    .raddr (ia_next[AW-1:0]),
    .rdata (rd_a)
  );

  slm_ram #(.WIDTH(slm_pkg::VALUE_W), .DEPTH(LIST_DEPTH)) u_ram_b (
    .clk   (clk),
    .we    (we_b),
    .waddr (cnt_b[AW-1:0]),
    .wdata (value),
    .raddr (ib_next[AW-1:0]),
    .rdata (rd_b)
  );

  // sequencer, counts and flag
  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= slm_pkg::ST_IDLE;
      cnt_a  <= '0;
      cnt_b  <= '0;
      ia     <= '0;
      ib     <= '0;
      flag   <= 1'b0;
      strobe <= 1'b0;
    end else begin
      strobe <= 1'b0;
      ia     <= ia_next;
      ib     <= ib_next;
      unique case (state)
        slm_pkg::ST_IDLE: begin
          if (accept) begin
            priority if (command == slm_pkg::CMD_APPEND_A) begin
              if (we_a) cnt_a <= cnt_a + CW'(1);
              else      flag  <= 1'b1;
            end else if (command == slm_pkg::CMD_APPEND_B) begin
              if (we_b) cnt_b <= cnt_b + CW'(1);
              else      flag  <= 1'b1;
            end else if (command == slm_pkg::CMD_MERGE) begin
              flag <= 1'b0;
              if (total == '0) begin
                strobe <= 1'b1;
              end else begin
                state <= slm_pkg::ST_MERGE;
              end
            end else begin
              flag <= flag;
            end
          end
        end
        slm_pkg::ST_MERGE: begin
          strobe <= 1'b1;
          if (final_word) begin
            state <= slm_pkg::ST_IDLE;
            cnt_a <= '0;
            cnt_b <= '0;
          end
        end
        default: state <= slm_pkg::ST_IDLE;
      endcase
    end
  end

  // result word registers
  always_ff @(posedge clk) begin
    if (state == slm_pkg::ST_IDLE) begin
      if (accept && (command == slm_pkg::CMD_MERGE)) begin
        drop_hold <= flag;
        value_res <= '0;
        last      <= 1'b1;
        empty_res <= 1'b1;
        dropped   <= flag;
      end
    end else begin
      value_res <= take_b ? rd_b : rd_a;
      last      <= final_word;
      empty_res <= 1'b0;
      dropped   <= drop_hold;
    end
  end

endmodule

FILE: design/slm_ram.sv
// generic single write port, single read port ram with registered read
module slm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: design/slm_checker.sv
// port-level checker for the sorted list merge block, with its bind
module slm_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       start,
  input logic                       busy,
  input logic [1:0]                 command,
  input logic [slm_pkg::VALUE_W-1:0] value_res,
  input logic                       strobe,
  input logic                       last,
  input logic                       empty_res
);

  // a merge command is answered at once by a result or by going busy
  a_merge_answered: assert property (@(posedge clk) disable iff (rst)
    (start && !busy && (command == slm_pkg::CMD_MERGE)) |=> (busy || strobe))
    else $error("merge command neither started nor answered");

  // an empty result is the only word of its run and carries zero
  a_empty_word: assert property (@(posedge clk) disable iff (rst)
    (strobe && empty_res) |-> (last && (value_res == '0)))
    else $error("empty result malformed");

  // words of a merge run come in consecutive cycles
  a_run_unbroken: assert property (@(posedge clk) disable iff (rst)
    (strobe && !last) |=> strobe)
    else $error("gap inside merge run");

  // busy holds exactly while more words of the run are due
  a_busy_matches_run: assert property (@(posedge clk) disable iff (rst)
    strobe |-> (last == !busy))
    else $error("busy does not match merge run");

endmodule

bind sorted_list_merge slm_checker u_slm_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .command   (command),
  .value_res (value_res),
  .strobe    (strobe),
  .last      (last),
  .empty_res (empty_res)
);

FILE: sim/sorted_list_merge_tb.sv
`timescale 1ns / 1ps
// testbench for sorted_list_merge: directed and random list loads against a merge predictor
module sorted_list_merge_tb;

  // one merged output word
  typedef struct {
    logic signed [slm_pkg::VALUE_W-1:0] val;
    logic                               last;
    logic                               empty;
    logic                               drop;
  } merged_word_t;

  logic                               clk = 1'b0;
  logic                               rst = 1'b1;
  logic                               start = 1'b0;
  logic [1:0]                         command = slm_pkg::CMD_NONE;
  logic signed [slm_pkg::VALUE_W-1:0] value = '0;
  logic                               busy;
  logic                               strobe;
  logic signed [slm_pkg::VALUE_W-1:0] value_res;
  logic                               last;
  logic                               empty_res;
  logic                               dropped;

  // predictor copy of the two lists and the sticky overflow
  logic signed [slm_pkg::VALUE_W-1:0] list_a[$];
  logic signed [slm_pkg::VALUE_W-1:0] list_b[$];
  logic                               overflow_seen = 1'b0;
  merged_word_t                       merged_words[$];

  int mismatches = 0;
  int random_words = 0;
  bit gaps_on = 1'b1;

  sorted_list_merge uut (
    .clk       (clk),
    .rst       (rst),
    .start     (start),
    .busy      (busy),
    .command   (command),
    .value     (value),
    .strobe    (strobe),
    .value_res (value_res),
    .last      (last),
    .empty_res (empty_res),
    .dropped   (dropped)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // update the list copies and queue the merged words a command gives
  function automatic void track_command(slm_pkg::cmd_t cmd,
                                        logic signed [slm_pkg::VALUE_W-1:0] v);
    int ia;
    int ib;
    int total;
    bit take_b;
    merged_word_t w;
    ia = 0;
    ib = 0;
    case (cmd)
      slm_pkg::CMD_APPEND_A: begin
        if (list_a.size() < slm_pkg::LIST_DEPTH) list_a.push_back(v);
        else overflow_seen = 1'b1;
      end
      slm_pkg::CMD_APPEND_B: begin
        if (list_b.size() < slm_pkg::LIST_DEPTH) list_b.push_back(v);
        else overflow_seen = 1'b1;
      end
      slm_pkg::CMD_MERGE: begin
        total = list_a.size() + list_b.size();
        w.drop = overflow_seen;
        w.empty = 1'b0;
        if (total == 0) begin
          w.val = '0;
          w.last = 1'b1;
          w.empty = 1'b1;
          merged_words.push_back(w);
        end
        // smaller head first, list b wins a tie
        while (ia < list_a.size() || ib < list_b.size()) begin
          if (ia >= list_a.size()) take_b = 1'b1;
          else if (ib >= list_b.size()) take_b = 1'b0;
          else take_b = (list_b[ib] <= list_a[ia]);
          if (take_b) begin
            w.val = list_b[ib];
            ib++;
          end else begin
            w.val = list_a[ia];
            ia++;
          end
          w.last = (ia + ib == total);
          merged_words.push_back(w);
        end
        list_a.delete();
        list_b.delete();
        overflow_seen = 1'b0;
      end
      default: ;
    endcase
  endfunction

  // drive one word, optionally after a gap; called and returns just after a falling edge
  task automatic send_word(input slm_pkg::cmd_t cmd,
                           input logic signed [slm_pkg::VALUE_W-1:0] v);
    int gap;
    int r;
    gap = 0;
    if (gaps_on) begin
      r = $urandom_range(0, 99);
      if (r >= 90) gap = $urandom_range(5, 40);
      else if (r >= 55) gap = $urandom_range(1, 3);
    end
    // idle with junk on the command lines
    if (gap > 0) begin
      start <= 1'b0;
      command <= 2'($urandom_range(0, 3));
      value <= $urandom;
      repeat (gap) @(negedge clk);
    end
    start <= 1'b1;
    command <= cmd;
    value <= v;
    do @(posedge clk); while (busy);
    track_command(cmd, v);
    @(negedge clk);
  endtask

  // list length, mostly short, now and then near, at or past full
  function automatic int pick_size();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(0, 5);
    if (r < 92) return $urandom_range(6, 16);
    return $urandom_range(slm_pkg::LIST_DEPTH - 4, slm_pkg::LIST_DEPTH + 2);
  endfunction

  // 0 narrow range with many ties, 1 wide ascending, 2 unsorted
  function automatic int pick_mode();
    int r;
    r = $urandom_range(0, 99);
    if (r < 35) return 0;
    if (r < 88) return 1;
    return 2;
  endfunction

  function automatic longint start_value(int mode);
    logic signed [slm_pkg::VALUE_W-1:0] t;
    t = $urandom;
    if (mode == 0) return longint'($urandom_range(0, 8)) - 4;
    if ($urandom_range(0, 9) == 0) return -64'sd2147483648;
    return t;
  endfunction

  function automatic logic signed [slm_pkg::VALUE_W-1:0] next_value(inout longint cur,
                                                                    input int mode);
    logic signed [slm_pkg::VALUE_W-1:0] r;
    r = cur[slm_pkg::VALUE_W-1:0];
    case (mode)
      0: cur = cur + longint'($urandom_range(0, 2));
      1: begin
        if ($urandom_range(0, 3) != 0) cur = cur + longint'($urandom_range(1, 1 << 24));
        if (cur > 64'sd2147483647) cur = 64'sd2147483647;
      end
      default: r = $urandom;
    endcase
    return r;
  endfunction

  // compare each strobed word with the oldest expected one
  always @(posedge clk) begin : check_word
    merged_word_t want;
    if (!rst && strobe) begin
      if (merged_words.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected word: value %0d last %0b empty %0b dropped %0b",
                   value_res, last, empty_res, dropped);
      end else begin
        want = merged_words.pop_front();
        if (value_res !== want.val || last !== want.last ||
            empty_res !== want.empty || dropped !== want.drop) begin
          mismatches++;
          if (mismatches <= 10)
            $display({"mismatch: exp value %0d last %0b empty %0b dropped %0b, ",
                      "got value %0d last %0b empty %0b dropped %0b"},
                     want.val, want.last, want.empty, want.drop,
                     value_res, last, empty_res, dropped);
        end
      end
    end
  end

  // merges with nothing loaded
  task automatic test_empty_merge();
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
    send_word(slm_pkg::CMD_MERGE, -32'sd1);
  endtask

  // extreme values on both lists, an unknown command in between
  task automatic test_extremes();
    send_word(slm_pkg::CMD_APPEND_A, 32'sh8000_0000);
    send_word(slm_pkg::CMD_APPEND_B, 32'sh8000_0000);
    send_word(slm_pkg::CMD_APPEND_A, -32'sd1);
    send_word(slm_pkg::CMD_NONE, 32'sh7fff_ffff);
    send_word(slm_pkg::CMD_APPEND_A, 32'sd0);
    send_word(slm_pkg::CMD_APPEND_B, 32'sd0);
    send_word(slm_pkg::CMD_APPEND_A, 32'sh7fff_ffff);
    send_word(slm_pkg::CMD_APPEND_B, 32'sh7fff_ffff);
    send_word(slm_pkg::CMD_MERGE, 32'sh5555_aaaa);
  endtask

  // ties, one list empty, lists out of order
  task automatic test_ties_and_one_sided();
    send_word(slm_pkg::CMD_APPEND_A, 32'sd5);
    send_word(slm_pkg::CMD_APPEND_A, 32'sd5);
    send_word(slm_pkg::CMD_APPEND_B, 32'sd5);
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
    send_word(slm_pkg::CMD_APPEND_A, 32'sd1);
    send_word(slm_pkg::CMD_APPEND_A, 32'sd2);
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
    send_word(slm_pkg::CMD_APPEND_B, -32'sd3);
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
    send_word(slm_pkg::CMD_APPEND_A, 32'sd9);
    send_word(slm_pkg::CMD_APPEND_A, 32'sd1);
    send_word(slm_pkg::CMD_APPEND_B, 32'sd4);
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
  endtask

  // both lists full, pushes past the end dropped, flag cleared by the merge
  task automatic test_full_lists();
    gaps_on = 1'b0;
    for (int i = 0; i < slm_pkg::LIST_DEPTH; i++) begin
      send_word(slm_pkg::CMD_APPEND_A, 32'(i * 3 - 40));
      send_word(slm_pkg::CMD_APPEND_B, 32'(i * 3 - 41));
    end
    gaps_on = 1'b1;
    send_word(slm_pkg::CMD_APPEND_A, 32'sd1000);
    send_word(slm_pkg::CMD_APPEND_B, -32'sd1000);
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
    send_word(slm_pkg::CMD_APPEND_B, 32'sd7);
    send_word(slm_pkg::CMD_MERGE, 32'sd0);
  endtask

  // random loads of both lists, each followed by a merge
  task automatic test_random_bursts();
    int na;
    int nb;
    int ia;
    int ib;
    int mode_a;
    int mode_b;
    longint cur_a;
    longint cur_b;
    while (random_words < 165) begin
      gaps_on = ($urandom_range(0, 4) != 0);
      na = pick_size();
      nb = pick_size();
      mode_a = pick_mode();
      mode_b = ($urandom_range(0, 3) == 0) ? pick_mode() : mode_a;
      cur_a = start_value(mode_a);
      cur_b = start_value(mode_b);
      ia = 0;
      ib = 0;
      // interleave the two lists, with the odd unknown command
      while (ia < na || ib < nb) begin
        if ($urandom_range(0, 99) < 6) begin
          send_word(slm_pkg::CMD_NONE, $urandom);
        end else if (ib >= nb || (ia < na && $urandom_range(0, 1) == 1)) begin
          send_word(slm_pkg::CMD_APPEND_A, next_value(cur_a, mode_a));
          ia++;
          random_words++;
        end else begin
          send_word(slm_pkg::CMD_APPEND_B, next_value(cur_b, mode_b));
          ib++;
          random_words++;
        end
      end
      send_word(slm_pkg::CMD_MERGE, $urandom);
      random_words++;
    end
  endtask

  // sequence of tests and final verdict
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_empty_merge();
    test_extremes();
    test_ties_and_one_sided();
    test_full_lists();
    test_random_bursts();
    start <= 1'b0;
    while (merged_words.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    mismatches += merged_words.size();
    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // watchdog
  initial begin
    #5000000;
    $display("simulation failed");
    $finish;
  end

endmodule
